FILE: hw/rtl/volume_box_downsample_2x2x2_unit_defines.svh
// Assertion macros for the volume box downsample unit.
// Included by modules that check their own control logic; no other dependencies.
`ifndef VOLUME_BOX_DOWNSAMPLE_2X2X2_UNIT_DEFINES_SVH
`define VOLUME_BOX_DOWNSAMPLE_2X2X2_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define VBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger in this cycle implies a condition in the next cycle.
`define VBD_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: hw/rtl/vbd_pkg.sv
// Shared types, constants and helper functions for the volume box downsample unit.
// No dependencies; imported by every module of the unit.
`timescale 1ns / 1ps

package vbd_pkg;

  // Channel and field sizes
  localparam int NCH     = 4;
  localparam int OUT_W   = 32;
  localparam int COORD_W = 5;
  localparam int POS_W   = 6;
  localparam int DIM_W   = 7;
  localparam int NCH_W   = 3;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH   = 64;
  localparam int DEF_MAX_HEIGHT  = 64;
  localparam int DEF_SAMPLE_BITS = 32;

  // Absolute dimension ceiling of the position counters
  localparam int DIM_CEIL = 64;

  // Register reset values
  localparam logic [DIM_W-1:0] RST_DIM = 7'd64;
  localparam logic [NCH_W-1:0] RST_NCH = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SRC_DEPTH  = 2'd2;
  localparam logic [1:0] REG_CHAN_COUNT = 2'd3;

  // Per-word control carried alongside the samples into the accumulator
  typedef struct packed {
    logic               first;
    logic               last;
    logic               done;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [COORD_W-1:0] dest_z;
  } vbd_ctrl_t;

  // One finished destination voxel
  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] dest_z;
    logic [COORD_W-1:0] dest_y;
    logic [COORD_W-1:0] dest_x;
    logic [NCH-1:0][OUT_W-1:0] avg;
  } vbd_res_t;

  // Round a dimension down to even and clamp it into [2, top]
  function automatic logic [DIM_W-1:0] fit_dim(input logic [DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] top);
    logic [DIM_W-1:0] r;
    r = {v[DIM_W-1:1], 1'b0};
    if (r < 7'd2) r = 7'd2;
    if (r > top) r = top;
    return r;
  endfunction

  // Clamp the channel count into [1, 4]
  function automatic logic [NCH_W-1:0] fit_nch(input logic [NCH_W-1:0] v);
    logic [NCH_W-1:0] r;
    r = v;
    if (r < 3'd1) r = 3'd1;
    if (r > 3'd4) r = 3'd4;
    return r;
  endfunction

endpackage

FILE: hw/rtl/vbd_acc.sv
// Partial-sum memory and read-modify-write pipeline of the downsample unit.
// Depends on vbd_pkg for the control and result structs.
`timescale 1ns / 1ps
`include "volume_box_downsample_2x2x2_unit_defines.svh"

module vbd_acc #(
  parameter int IDX_W      = 10,
  parameter int PART_DEPTH = 1024,
  parameter int SUM_W      = 35,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_vld_i,
  input  logic [IDX_W-1:0]                     in_idx_i,
  input  logic [vbd_pkg::NCH-1:0][SUM_W-1:0]   in_smp_i,
  input  vbd_pkg::vbd_ctrl_t                   in_ctrl_i,
  output logic                                 push_o,
  output vbd_pkg::vbd_res_t                    res_o,
  output logic                                 pend_o
);
  import vbd_pkg::*;

  localparam int ROW_W = NCH * SUM_W;

  logic [ROW_W-1:0]              part_mem [PART_DEPTH];
  logic [ROW_W-1:0]              rd_q;
  logic                          s1_vld_q;
  logic [IDX_W-1:0]              s1_idx_q;
  logic [NCH-1:0][SUM_W-1:0]     s1_smp_q;
  vbd_ctrl_t                     s1_ctrl_q;
  logic                          fw_vld_q;
  logic [IDX_W-1:0]              fw_idx_q;
  logic [ROW_W-1:0]              fw_data_q;
  logic [ROW_W-1:0]              base;
  logic [NCH-1:0][SUM_W-1:0]     sum;
  logic signed [SAMPLE_BITS-1:0] avg [NCH];

  // Read the partial row as the word is accepted
  always_ff @(posedge clk_i) begin
    if (in_vld_i) begin
      rd_q <= part_mem[in_idx_i];
    end
  end

  // Write back the updated row
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      part_mem[s1_idx_q] <= sum;
    end
  end

  // Advance the update stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      fw_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_vld_i;
      fw_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= in_idx_i;
    s1_smp_q  <= in_smp_i;
    s1_ctrl_q <= in_ctrl_i;
    fw_idx_q  <= s1_idx_q;
    fw_data_q <= sum;
  end

  // Forward the row written on the same edge the read was issued
  assign base = (fw_vld_q && (fw_idx_q == s1_idx_q)) ? fw_data_q : rd_q;

  // Start a fresh sum on the first cube member, else accumulate
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (s1_ctrl_q.first) begin
        sum[c] = s1_smp_q[c];
      end else begin
        sum[c] = base[c*SUM_W +: SUM_W] + s1_smp_q[c];
      end
      avg[c] = sum[c][SUM_W-1:3];
    end
  end

  // Emit the average on the eighth member
  always_comb begin
    res_o.done   = s1_ctrl_q.done;
    res_o.dest_x = s1_ctrl_q.dest_x;
    res_o.dest_y = s1_ctrl_q.dest_y;
    res_o.dest_z = s1_ctrl_q.dest_z;
    for (int c = 0; c < NCH; c++) begin
      res_o.avg[c] = OUT_W'(avg[c]);
    end
  end

  assign push_o = s1_vld_q && s1_ctrl_q.last;
  assign pend_o = push_o;

  `VBD_ASSERT(a_last_not_first, !(s1_vld_q && s1_ctrl_q.first && s1_ctrl_q.last),
              "cube member marked both first and last")
  `VBD_ASSERT_NEXT(a_fwd_follows, s1_vld_q, fw_vld_q && (fw_idx_q == $past(s1_idx_q)),
                   "forwarding register lost the written row")

endmodule

FILE: hw/rtl/vbd_ofifo.sv
// Two-entry output queue that decouples finished voxels from the stream sink.
// Depends on vbd_pkg for the result struct.
`timescale 1ns / 1ps
`include "volume_box_downsample_2x2x2_unit_defines.svh"

module vbd_ofifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vbd_pkg::vbd_res_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output vbd_pkg::vbd_res_t data_o,
  output logic [1:0]        cnt_o
);
  import vbd_pkg::*;

  vbd_res_t   ent_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign data_o  = ent_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

  // Track occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
    end
  end

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

  `VBD_ASSERT(a_no_overflow, !(push_i && (cnt_q == 2'd2) && !pop),
              "output queue overflow")
  `VBD_ASSERT(a_cnt_range, cnt_q != 2'd3, "output queue count out of range")

endmodule

FILE: hw/rtl/volume_box_downsample_2x2x2_unit.sv
// Throughput: one source word per cycle while s_axis_tready is high; each is
// registered in the vbd_acc update stage and does one read-modify-write of the
// partial-sum memory row, with the previous row write forwarded on a match.
// Reset: positions and queue clear, registers go to 64/64/64/4; the partial-sum
// memory is not cleared, since the first cube member always overwrites its row.
// Top level of the 2x2x2 volume downsampler; uses vbd_pkg, vbd_acc, vbd_ofifo.
`timescale 1ns / 1ps
`include "volume_box_downsample_2x2x2_unit_defines.svh"

module volume_box_downsample_2x2x2_unit #(
  parameter int MAX_WIDTH   = vbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = vbd_pkg::DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = vbd_pkg::DEF_SAMPLE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave side: chan_a, chan_b, chan_c, chan_d (32 bits each), lowest bit up
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [127:0]                 s_axis_tdata,
  // master side: avg_a, avg_b, avg_c, avg_d (32 each), dest_x, dest_y, dest_z
  // (5 each), one zero pad bit; tlast is volume_done
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [143:0]                 m_axis_tdata,
  output logic                         m_axis_tlast,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vbd_pkg::ADDR_W-1:0]   paddr,
  input  logic [vbd_pkg::DATA_W-1:0]   pwdata,
  output logic [vbd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import vbd_pkg::*;

  localparam int HALF_W     = MAX_WIDTH / 2;
  localparam int HALF_H     = MAX_HEIGHT / 2;
  localparam int PART_DEPTH = HALF_W * HALF_H;
  localparam int IDX_W      = (PART_DEPTH > 1) ? $clog2(PART_DEPTH) : 1;
  localparam int SUM_W      = SAMPLE_BITS + 3;
  localparam int TOP_W      = ((MAX_WIDTH < DIM_CEIL) ? MAX_WIDTH : DIM_CEIL) / 2 * 2;
  localparam int TOP_H      = ((MAX_HEIGHT < DIM_CEIL) ? MAX_HEIGHT : DIM_CEIL) / 2 * 2;
  localparam int TOP_D      = DIM_CEIL;

  logic [DIM_W-1:0]          src_w_q, src_h_q, src_d_q;
  logic [NCH_W-1:0]          nch_q;
  logic [POS_W-1:0]          pos_x_q, pos_y_q, pos_z_q;
  logic [POS_W-1:0]          pos_x_d, pos_y_d, pos_z_d;
  logic [DIM_W-1:0]          w_eff, h_eff, d_eff;
  logic [NCH_W-1:0]          nch_eff;
  logic                      cfg_wr;
  logic                      in_acc;
  logic                      end_x, end_y, end_z;
  logic [IDX_W-1:0]          idx;
  logic [NCH-1:0][SUM_W-1:0] smp;
  logic signed [SAMPLE_BITS-1:0] raw [NCH];
  vbd_ctrl_t                 ctrl;
  logic                      push;
  logic                      pend;
  vbd_res_t                  res;
  vbd_res_t                  out_res;
  logic [1:0]                ofifo_cnt;

  // Register file access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= RST_DIM;
      src_h_q <= RST_DIM;
      src_d_q <= RST_DIM;
      nch_q   <= RST_NCH;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SRC_WIDTH:  src_w_q <= pwdata[DIM_W-1:0];
        REG_SRC_HEIGHT: src_h_q <= pwdata[DIM_W-1:0];
        REG_SRC_DEPTH:  src_d_q <= pwdata[DIM_W-1:0];
        REG_CHAN_COUNT: nch_q   <= pwdata[NCH_W-1:0];
        default:        nch_q   <= nch_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SRC_WIDTH:  prdata = DATA_W'(src_w_q);
      REG_SRC_HEIGHT: prdata = DATA_W'(src_h_q);
      REG_SRC_DEPTH:  prdata = DATA_W'(src_d_q);
      REG_CHAN_COUNT: prdata = DATA_W'(nch_q);
      default:        prdata = '0;
    endcase
  end

  // Effective dimensions and channel count
  assign w_eff   = fit_dim(src_w_q, DIM_W'(TOP_W));
  assign h_eff   = fit_dim(src_h_q, DIM_W'(TOP_H));
  assign d_eff   = fit_dim(src_d_q, DIM_W'(TOP_D));
  assign nch_eff = fit_nch(nch_q);

  // Accept while the queue can take any result still in flight
  assign s_axis_tready = (ofifo_cnt == 2'd0) || ((ofifo_cnt == 2'd1) && !pend);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Raster position sequencer
  assign end_x = ({1'b0, pos_x_q} == (w_eff - 7'd1));
  assign end_y = ({1'b0, pos_y_q} == (h_eff - 7'd1));
  assign end_z = ({1'b0, pos_z_q} == (d_eff - 7'd1));

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    if (cfg_wr) begin
      pos_x_d = '0;
      pos_y_d = '0;
      pos_z_d = '0;
    end else if (in_acc) begin
      pos_x_d = pos_x_q + 6'd1;
      if (end_x) begin
        pos_x_d = '0;
        pos_y_d = pos_y_q + 6'd1;
        if (end_y) begin
          pos_y_d = '0;
          pos_z_d = end_z ? '0 : pos_z_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
    end
  end

  // Row address within the destination slice
  assign idx = IDX_W'(32'(pos_y_q[POS_W-1:1]) * HALF_W + 32'(pos_x_q[POS_W-1:1]));

  // Cube membership and destination coordinates
  always_comb begin
    ctrl.first  = !(pos_x_q[0] || pos_y_q[0] || pos_z_q[0]);
    ctrl.last   = pos_x_q[0] && pos_y_q[0] && pos_z_q[0];
    ctrl.done   = end_x && end_y && end_z;
    ctrl.dest_x = pos_x_q[POS_W-1:1];
    ctrl.dest_y = pos_y_q[POS_W-1:1];
    ctrl.dest_z = pos_z_q[POS_W-1:1];
  end

  // Sign-extend samples, drop channels not in use
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      raw[c] = s_axis_tdata[c*OUT_W +: SAMPLE_BITS];
      smp[c] = (NCH_W'(c) < nch_eff) ? SUM_W'(raw[c]) : '0;
    end
  end

  vbd_acc #(
    .IDX_W      (IDX_W),
    .PART_DEPTH (PART_DEPTH),
    .SUM_W      (SUM_W),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (in_acc),
    .in_idx_i (idx),
    .in_smp_i (smp),
    .in_ctrl_i(ctrl),
    .push_o   (push),
    .res_o    (res),
    .pend_o   (pend)
  );

  vbd_ofifo u_ofifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (res),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (out_res),
    .cnt_o  (ofifo_cnt)
  );

  // Pack the result word
  assign m_axis_tdata = {1'b0, out_res.dest_z, out_res.dest_y, out_res.dest_x, out_res.avg};
  assign m_axis_tlast = out_res.done;

  `VBD_ASSERT(a_pos_in_range,
              ({1'b0, pos_x_q} < w_eff) && ({1'b0, pos_y_q} < h_eff) &&
              ({1'b0, pos_z_q} < d_eff),
              "raster position outside the volume")
  `VBD_ASSERT_NEXT(a_done_wraps, in_acc && ctrl.done,
                   (pos_x_q == '0) && (pos_y_q == '0) && (pos_z_q == '0),
                   "position did not wrap after the last voxel")
  `VBD_ASSERT(a_no_drop, !(push && (ofifo_cnt == 2'd2) && !m_axis_tready),
              "result produced with no room in the output queue")

endmodule
